// File: design/bbcd_pkg.sv
// shared types, codes and field layout for the buffer cache directory
// no dependencies; used by the directory core and its port checker
`default_nettype none

package bbcd_pkg;

	// default sizing handed to the top level
	localparam int NUM_BUFFERS_DEF = 32;
	localparam int COUNT_BITS_DEF  = 8;

	// fixed field widths
	localparam int MODE_W   = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int IDX_W    = 5;
	localparam int TIME_W   = 32;
	localparam int STATUS_W = 2;

	// request tdata layout, lowest bit first
	localparam int DEV_LSB      = 0;
	localparam int BLK_LSB      = DEV_LSB + DEV_W;
	localparam int IDX_LSB      = BLK_LSB + BLK_W;
	localparam int NOW_LSB      = IDX_LSB + IDX_W;
	localparam int IN_FIELDS_W  = NOW_LSB + TIME_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

	// result tdata layout, lowest bit first
	localparam int BUF_LSB      = 0;
	localparam int HIT_BIT      = BUF_LSB + IDX_W;
	localparam int RD_BIT       = HIT_BIT + 1;
	localparam int STATUS_LSB   = RD_BIT + 1;
	localparam int OUT_FIELDS_W = STATUS_LSB + STATUS_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_GET     = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_PIN     = 2'd2,
		MODE_UNPIN   = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NO_FREE   = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

endpackage

`default_nettype wire

// File: design/block_buffer_cache_directory_core.sv
// buffer cache directory: tag lookup, lru victim pick and reference counting
// depends on bbcd_pkg; entry records sit in one memory with a read and a write port
//
// Usage:
//  - requests enter on s_axis (tuser = kind, tdata = device, block number,
//    entry index, current tick); results leave on m_axis (tdata = buffer
//    index, hit, needs_read, status).
//  - one request is worked on at a time. A get reads every entry once
//    through the memory read port, one entry per cycle, to find the first
//    tag match and the free entry with the oldest release time; the next
//    request is taken only once the current result is in the output register.
//  - release, pin and unpin read and write back the one addressed entry;
//    an index beyond the table skips the read.
//  - the write back happens only once the prior read has landed, so reads
//    and writes of one entry never overlap.
//  - reset clears a per-entry written flag; an entry never written reads as
//    all zero, so no clearing pass is needed and requests are taken at once.
//  - a stalled result holds in the output register; the block still takes
//    the next request and finishes it up to the point where it must report.
`default_nettype none

module block_buffer_cache_directory_core #(
	parameter int NUM_BUFFERS = bbcd_pkg::NUM_BUFFERS_DEF,
	parameter int COUNT_BITS  = bbcd_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output      logic                              s_axis_tready,
	// device[7:0], block_number[39:8], entry_index[44:40], now[76:45]
	input  wire logic [bbcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input  wire logic [bbcd_pkg::MODE_W-1:0]       s_axis_tuser,
	output      logic                              m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// buffer_index[4:0], hit[5], needs_read[6], status[8:7]
	output      logic [bbcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import bbcd_pkg::*;

	localparam int AW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BUFFERS - 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

	typedef struct packed {
		logic [DEV_W-1:0]      dev;
		logic [BLK_W-1:0]      blk;
		logic                  valid;
		logic [COUNT_BITS-1:0] cnt;
		logic [TIME_W-1:0]     rtime;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_WAIT   = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t state_q;

	// latched request
	mode_t             mode_q;
	logic [DEV_W-1:0]  dev_q;
	logic [BLK_W-1:0]  blk_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic              in_range_q;

	// scan bookkeeping
	logic [AW-1:0]     cnt_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     addr_s1;
	entry_t            rd_ent_s1;
	logic              hit_fnd_q;
	logic [AW-1:0]     hit_idx_q;
	entry_t            cur_ent_q;
	logic              free_fnd_q;
	logic [AW-1:0]     best_idx_q;
	logic [TIME_W-1:0] best_time_q;

	// entry memory and its written flags
	entry_t           mem [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] written_q;

	logic              accept;
	logic              mem_re;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_ent;
	entry_t            ent_s1;
	logic              ent_match;
	logic              ent_free;
	logic              req_in_range;
	logic              out_load;
	logic              out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [IDX_W-1:0]  res_idx;
	logic              res_hit;
	logic              res_rd;
	status_t           res_status;
	logic              res_we;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign req_in_range  = (32'(s_axis_tdata[IDX_LSB +: IDX_W]) < 32'(NUM_BUFFERS));

	// scan counter drives the read port address
	assign mem_re  = (state_q == S_SCAN);
	assign rd_addr = cnt_q;

	// an entry never written reads as its reset value
	assign ent_s1    = written_q[addr_s1] ? rd_ent_s1 : '0;
	assign ent_match = (ent_s1.dev == dev_q) && (ent_s1.blk == blk_q);
	assign ent_free  = (ent_s1.cnt == '0);

	// memory array
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_ent;
		end
		if (mem_re) begin
			rd_ent_s1 <= mem[rd_addr];
		end
	end

	// written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (mem_we) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode_t'(s_axis_tuser) == MODE_GET) begin
							cnt_q   <= '0;
							state_q <= S_SCAN;
						end else if (req_in_range) begin
							cnt_q   <= AW'(s_axis_tdata[IDX_LSB +: IDX_W]);
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_SCAN: begin
					if (mode_q == MODE_GET && cnt_q != LAST_ADDR) begin
						cnt_q <= cnt_q + AW'(1);
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// search flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (accept) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (rd_vld_s1 && mode_q == MODE_GET) begin
			if (ent_match) begin
				hit_fnd_q <= 1'b1;
			end
			if (ent_free) begin
				free_fnd_q <= 1'b1;
			end
		end
	end

	// request fields and scan payload
	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (accept) begin
			mode_q     <= mode_t'(s_axis_tuser);
			dev_q      <= s_axis_tdata[DEV_LSB +: DEV_W];
			blk_q      <= s_axis_tdata[BLK_LSB +: BLK_W];
			idx_q      <= s_axis_tdata[IDX_LSB +: IDX_W];
			now_q      <= s_axis_tdata[NOW_LSB +: TIME_W];
			in_range_q <= req_in_range;
		end
		if (rd_vld_s1) begin
			// first tag match, or the addressed entry
			if (mode_q != MODE_GET || (ent_match && !hit_fnd_q)) begin
				cur_ent_q <= ent_s1;
				hit_idx_q <= addr_s1;
			end
			// oldest free entry, lowest index on a tie
			if (mode_q == MODE_GET && ent_free &&
			    (!free_fnd_q || ent_s1.rtime < best_time_q)) begin
				best_idx_q  <= addr_s1;
				best_time_q <= ent_s1.rtime;
			end
		end
	end

	// outcome of the request and the write back
	always_comb begin
		res_idx    = idx_q;
		res_hit    = 1'b0;
		res_rd     = 1'b0;
		res_status = STAT_OK;
		res_we     = 1'b0;
		wr_addr    = hit_idx_q;
		wr_ent     = cur_ent_q;
		unique case (mode_q) inside
			MODE_GET: begin
				if (hit_fnd_q) begin
					res_idx = IDX_W'(hit_idx_q);
					res_hit = 1'b1;
					if (cur_ent_q.cnt == CNT_MAX) begin
						res_status = STAT_OVERFLOW;
					end else begin
						res_rd       = !cur_ent_q.valid;
						res_we       = 1'b1;
						wr_ent.cnt   = cur_ent_q.cnt + COUNT_BITS'(1);
						wr_ent.valid = 1'b1;
					end
				end else if (free_fnd_q) begin
					res_idx      = IDX_W'(best_idx_q);
					res_rd       = 1'b1;
					res_we       = 1'b1;
					wr_addr      = best_idx_q;
					wr_ent.dev   = dev_q;
					wr_ent.blk   = blk_q;
					wr_ent.valid = 1'b1;
					wr_ent.cnt   = COUNT_BITS'(1);
					wr_ent.rtime = best_time_q;
				end else begin
					res_idx    = '0;
					res_status = STAT_NO_FREE;
				end
			end
			MODE_PIN: begin
				if (in_range_q) begin
					if (cur_ent_q.cnt == CNT_MAX) begin
						res_status = STAT_OVERFLOW;
					end else begin
						res_we     = 1'b1;
						wr_ent.cnt = cur_ent_q.cnt + COUNT_BITS'(1);
					end
				end
			end
			MODE_RELEASE, MODE_UNPIN: begin
				if (in_range_q) begin
					if (cur_ent_q.cnt == '0) begin
						res_status = STAT_UNDERFLOW;
					end else begin
						res_we     = 1'b1;
						wr_ent.cnt = cur_ent_q.cnt - COUNT_BITS'(1);
						// final release stamps the current tick
						if (mode_q == MODE_RELEASE && cur_ent_q.cnt == COUNT_BITS'(1)) begin
							wr_ent.rtime = now_q;
						end
					end
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	assign out_load = (state_q == S_DECIDE) && (!out_vld_q || m_axis_tready);
	assign mem_we   = out_load && res_we;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, res_status, res_rd, res_hit, res_idx};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: design/bbcd_checker.sv
// port-level checks for the buffer cache directory core, bound to the top level
// depends on bbcd_pkg for field layout and status codes
`default_nettype none

module bbcd_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	// device[7:0], block_number[39:8], entry_index[44:40], now[76:45]
	input wire logic [bbcd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input wire logic [bbcd_pkg::MODE_W-1:0]       s_axis_tuser,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	// buffer_index[4:0], hit[5], needs_read[6], status[8:7]
	input wire logic [bbcd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import bbcd_pkg::*;

	logic [STATUS_W-1:0] status;
	assign status = m_axis_tdata[STATUS_LSB +: STATUS_W];

	// a stalled result holds its fields
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while one is in progress");

	// no free buffer reports entry zero with no hit and no read
	a_no_free_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STAT_NO_FREE |->
		m_axis_tdata[BUF_LSB +: IDX_W] == '0 && !m_axis_tdata[HIT_BIT] && !m_axis_tdata[RD_BIT])
		else $error("no-free result carries nonzero fields");

	// a disk read is only asked for on success
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[RD_BIT] |-> status == STAT_OK)
		else $error("read requested with error status");

	// underflow comes from release or unpin, never with a hit
	a_underflow_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STAT_UNDERFLOW |-> !m_axis_tdata[HIT_BIT])
		else $error("underflow reported on a get hit");

endmodule

bind block_buffer_cache_directory_core bbcd_checker u_bbcd_checker (.*);

`default_nettype wire
